/* hw/rtl/rwtc_pkg.sv */
// ----------------------------------------------------------------------------
// rwtc_pkg: shared types and constants of the wall texture column mapper
// Request codes, face codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package rwtc_pkg;

    localparam int NUM_FACES = 4;
    localparam int MAX_ROWS  = 1024;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    localparam logic CFG_TEX_SIZE_LOG2 = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [2:0]  TEX_SIZE_LOG2_RESET = 3'd6;
    localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd480;

    localparam logic [23:0] DARK_MASK = 24'h7F7F7F;

    typedef enum logic [1:0] {
        FACE_N = 2'd0,
        FACE_S = 2'd1,
        FACE_E = 2'd2,
        FACE_W = 2'd3
    } t_face;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_MUL
    } t_state;

endpackage

/* hw/rtl/rwtc_divider.sv */
// ----------------------------------------------------------------------------
// rwtc_divider: texture step divider
// Restoring divider, one quotient bit per cycle: (1 << (lg + 16)) / den.
// ----------------------------------------------------------------------------
module rwtc_divider
    import rwtc_pkg::*;
#(
    parameter int MAX_TEX_LOG2 = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [$clog2(MAX_TEX_LOG2+1)-1:0] i_lg,
    input  logic [15:0]                 i_den,
    output logic                        o_done,
    output logic [MAX_TEX_LOG2+16:0]    o_quotient
);

    localparam int NUM_W = MAX_TEX_LOG2 + 17;
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [16:0]      r_rem;
    logic [15:0]      r_den;
    logic [CNT_W-1:0] r_count;
    logic             r_busy;
    logic             r_done;

    logic [16:0] w_rem_sh;
    logic        w_bit;
    logic [16:0] w_rem_next;

    always_comb begin
        w_rem_sh = {r_rem[15:0], r_num[NUM_W-1]};
        w_bit    = (w_rem_sh >= {1'b0, r_den});
        w_rem_next = w_bit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'(1) << (NUM_W'(i_lg) + NUM_W'(16));
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_rem_next;
            r_quo <= {r_quo[NUM_W-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/rwtc_texel_mem.sv */
// ----------------------------------------------------------------------------
// rwtc_texel_mem: texel store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rwtc_texel_mem
    import rwtc_pkg::*;
#(
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [23:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [23:0]       o_rdata
);

    logic [23:0] mem [2**ADDR_W];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/raycast_wall_texture_column.sv */
// ----------------------------------------------------------------------------
// raycast_wall_texture_column: wall texture column mapper
// Maps one raycast wall slice onto a texture column and emits its pixels.
// ----------------------------------------------------------------------------
// Texel writes and pixel steps sustain one word per cycle while the output is
// not stalled; a pixel passes from its step word through the fetch stage, a
// registered read on the single read port of the texel store, into the output
// register. A column start holds the input stalled while the step divider
// produces one quotient bit a cycle and a multiply state then forms the start
// position. The texel store holds 4 faces of 2^(2*MAX_TEX_LOG2) texels, is
// not cleared at reset and needs no start-up pass.
module raycast_wall_texture_column
    import rwtc_pkg::*;
#(
    parameter int MAX_TEX_LOG2 = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_face_select,
    input  logic [11:0] i_texel_addr,
    input  logic [23:0] i_texel_value,
    input  logic        i_hit_side,
    input  logic        i_dir_x_negative,
    input  logic        i_dir_y_positive,
    input  logic [15:0] i_wall_fraction,
    input  logic [15:0] i_line_height,
    input  logic [9:0]  i_draw_start,
    input  logic [10:0] i_draw_end,
    input  logic [10:0] i_column,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_pixel_row,
    output logic [10:0] o_pixel_column,
    output logic [23:0] o_pixel_color,
    output logic        o_write_enable,
    output logic        o_column_last,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int TW     = MAX_TEX_LOG2;
    localparam int SZ_W   = MAX_TEX_LOG2 + 1;
    localparam int LG_W   = $clog2(MAX_TEX_LOG2 + 1);
    localparam int IDX_W  = 2 * MAX_TEX_LOG2;
    localparam int ADDR_W = 2 + IDX_W;
    localparam int NUM_W  = MAX_TEX_LOG2 + 17;
    localparam int K_W    = 18;
    localparam int P_W    = K_W + NUM_W + 1;

    t_state             r_state, n_state;
    logic               w_div_start;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quotient;

    logic [2:0]         r_tex_size_log2;
    logic [10:0]        r_screen_height;

    logic [31:0]        r_tex_pos;
    logic [NUM_W-1:0]   r_step;
    t_face              r_face;
    logic [TW-1:0]      r_tcol;
    logic [10:0]        r_row;
    logic [10:0]        r_end;
    logic [10:0]        r_col;
    logic               r_active;
    logic [K_W-1:0]     r_k;

    logic               r_s1_valid;
    logic [9:0]         r_s1_row;
    logic [10:0]        r_s1_col;
    logic               r_s1_dark;
    logic               r_s1_last;

    logic               r_o_valid;
    logic [9:0]         r_o_row;
    logic [10:0]        r_o_col;
    logic [23:0]        r_o_color;
    logic               r_o_we;
    logic               r_o_last;

    logic [LG_W-1:0]    w_lg;
    logic [SZ_W-1:0]    w_size;
    logic [TW-1:0]      w_mask;
    logic               w_is_write, w_is_start, w_is_step;
    logic               w_in_acc, w_out_load, w_issue, w_write, w_start;
    t_face              w_face;
    logic [TW-1:0]      w_tx, w_tcol;
    logic [15:0]        w_lh;
    logic [K_W-1:0]     w_k;
    logic [10:0]        w_end;
    logic [TW-1:0]      w_ty;
    logic [IDX_W-1:0]   w_idx;
    logic [ADDR_W-1:0]  w_raddr, w_waddr;
    logic               w_last;
    logic [23:0]        w_rdata, w_color;
    logic signed [P_W-1:0] w_prod;

    // effective texture size
    always_comb begin
        if (r_tex_size_log2 == 3'd0) begin
            w_lg = LG_W'(1);
        end else if (int'(r_tex_size_log2) > MAX_TEX_LOG2) begin
            w_lg = LG_W'(MAX_TEX_LOG2);
        end else begin
            w_lg = LG_W'(r_tex_size_log2);
        end
        w_size = SZ_W'(1) << w_lg;
        w_mask = TW'(w_size - SZ_W'(1));
    end

    always_comb begin
        w_is_write = 1'b0;
        w_is_start = 1'b0;
        w_is_step  = 1'b0;
        unique case (i_req_type)
            REQ_WRITE: w_is_write = 1'b1;
            REQ_START: w_is_start = 1'b1;
            REQ_STEP:  w_is_step  = 1'b1;
            default: ;
        endcase
    end

    assign w_out_load = !r_o_valid || !i_stall;
    assign o_stall    = (r_state != ST_RUN) || (r_s1_valid && !w_out_load);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_write    = w_in_acc && w_is_write;
    assign w_start    = w_in_acc && w_is_start;
    assign w_issue    = w_in_acc && w_is_step && r_active;

    // column start decode
    always_comb begin
        if (!i_hit_side) begin
            w_face = i_dir_x_negative ? FACE_W : FACE_E;
        end else begin
            w_face = i_dir_y_positive ? FACE_S : FACE_N;
        end
        w_tx = TW'(i_wall_fraction >> (16 - int'(w_lg)));
        if (w_face == FACE_W || w_face == FACE_S) begin
            w_tcol = ~w_tx & w_mask;
        end else begin
            w_tcol = w_tx;
        end
        w_lh = (i_line_height == 16'd0) ? 16'd1 : i_line_height;
        w_k  = K_W'(i_draw_start) + K_W'(w_lh[15:1]) - K_W'(r_screen_height[10:1]);
        if (int'(i_draw_end) > MAX_ROWS) begin
            w_end = 11'(MAX_ROWS);
        end else begin
            w_end = i_draw_end;
        end
    end

    // pixel fetch address
    always_comb begin
        w_ty    = r_tex_pos[16 +: TW] & w_mask;
        w_idx   = (IDX_W'(w_ty) << w_lg) + IDX_W'(r_tcol);
        w_raddr = {r_face, w_idx};
        w_waddr = {i_face_select, IDX_W'(i_texel_addr)};
        w_last  = ({1'b0, r_row} + 12'd1) >= {1'b0, r_end};
    end

    assign w_prod = $signed(r_k) * $signed({1'b0, r_step});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (w_start) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_RUN;
            end
            default: n_state = ST_RUN;
        endcase
    end

    rwtc_divider #(
        .MAX_TEX_LOG2 (MAX_TEX_LOG2)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_lg       (w_lg),
        .i_den      (w_lh),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    rwtc_texel_mem #(
        .ADDR_W (ADDR_W)
    ) u_texel_mem (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (w_waddr),
        .i_wdata (i_texel_value),
        .i_re    (w_issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // config and column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_size_log2 <= TEX_SIZE_LOG2_RESET;
            r_screen_height <= SCREEN_HEIGHT_RESET;
            r_tex_pos       <= '0;
            r_step          <= '0;
            r_face          <= FACE_N;
            r_tcol          <= '0;
            r_row           <= '0;
            r_end           <= '0;
            r_col           <= '0;
            r_active        <= 1'b0;
            r_k             <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TEX_SIZE_LOG2: r_tex_size_log2 <= i_cfg_data[2:0];
                    CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_start) begin
                r_face   <= w_face;
                r_tcol   <= w_tcol;
                r_row    <= {1'b0, i_draw_start};
                r_end    <= w_end;
                r_col    <= i_column;
                r_active <= ({1'b0, i_draw_start} < w_end);
                r_k      <= w_k;
            end
            if (r_state == ST_DIV && w_div_done) begin
                r_step <= w_quotient;
            end
            if (r_state == ST_MUL) begin
                r_tex_pos <= w_prod[31:0];
            end
            if (w_issue) begin
                r_tex_pos <= r_tex_pos + 32'(r_step);
                r_row     <= r_row + 11'd1;
                if (w_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // fetch stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_issue) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_row  <= r_row[9:0];
            r_s1_col  <= r_col;
            r_s1_dark <= (r_face == FACE_N) || (r_face == FACE_E);
            r_s1_last <= w_last;
        end
        if (w_out_load && r_s1_valid) begin
            r_o_row   <= r_s1_row;
            r_o_col   <= r_s1_col;
            r_o_color <= w_color;
            r_o_we    <= (w_color != 24'd0);
            r_o_last  <= r_s1_last;
        end
    end

    assign w_color = r_s1_dark ? ((w_rdata >> 1) & DARK_MASK) : w_rdata;

    assign o_valid        = r_o_valid;
    assign o_pixel_row    = r_o_row;
    assign o_pixel_column = r_o_col;
    assign o_pixel_color  = r_o_color;
    assign o_write_enable = r_o_we;
    assign o_column_last  = r_o_last;
    assign o_cfg_ready    = 1'b1;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the wall texture column mapper
// Streams texel writes, column starts and pixel steps with random gaps and
// output stalls, predicts every pixel from a behavioral copy of the mapper
// and compares each emitted pixel field by field. Runs under several texture
// sizes and screen heights, the out-of-range sizes among them.
// ----------------------------------------------------------------------------
module tb_top
    import rwtc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TEX_LOG2_MAX    = 6;
    localparam int          FACE_DEPTH      = 1 << (2 * TEX_LOG2_MAX);
    localparam int          RANDOM_WORDS    = 1650;
    localparam int          PHASE_WORDS     = 240;
    localparam int          SETTLE_CYCLES   = TEX_LOG2_MAX + 30;
    localparam int          WATCHDOG_CYCLES = 4000;
    localparam logic [1:0]  REQ_UNUSED      = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [1:0]  face;
        logic [11:0] addr;
        logic [23:0] value;
        logic        side;
        logic        xneg;
        logic        ypos;
        logic [15:0] frac;
        logic [15:0] lh;
        logic [9:0]  ds;
        logic [10:0] de;
        logic [10:0] col;
    } t_word;

    typedef struct packed {
        logic [9:0]  row;
        logic [10:0] col;
        logic [23:0] color;
        logic        we;
        logic        last;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [1:0]  i_face_select;
    logic [11:0] i_texel_addr;
    logic [23:0] i_texel_value;
    logic        i_hit_side;
    logic        i_dir_x_negative;
    logic        i_dir_y_positive;
    logic [15:0] i_wall_fraction;
    logic [15:0] i_line_height;
    logic [9:0]  i_draw_start;
    logic [10:0] i_draw_end;
    logic [10:0] i_column;
    logic        o_valid;
    logic        i_stall;
    logic [9:0]  o_pixel_row;
    logic [10:0] o_pixel_column;
    logic [23:0] o_pixel_color;
    logic        o_write_enable;
    logic        o_column_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [10:0] i_cfg_data;

    // mapper state as the bench tracks it
    logic [23:0] texel_mem [NUM_FACES * FACE_DEPTH];
    bit          texel_seen [NUM_FACES * FACE_DEPTH];
    logic [31:0] tex_pos_q;
    logic [31:0] tex_step_q;
    t_face       face_q;
    logic [5:0]  tex_col_q;
    logic [10:0] row_q;
    logic [10:0] end_q;
    logic [10:0] col_q;
    bit          active_q;
    logic [2:0]  size_log2_q;
    logic [10:0] screen_height_q;

    t_pixel      expected_pixels [$];
    int          error_count;
    int          words_sent;
    int          pixels_checked;
    int          register_writes;
    int          quiet_cycles;
    bit          no_gaps;

    raycast_wall_texture_column #(
        .MAX_TEX_LOG2(TEX_LOG2_MAX)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_face_select(i_face_select),
        .i_texel_addr(i_texel_addr),
        .i_texel_value(i_texel_value),
        .i_hit_side(i_hit_side),
        .i_dir_x_negative(i_dir_x_negative),
        .i_dir_y_positive(i_dir_y_positive),
        .i_wall_fraction(i_wall_fraction),
        .i_line_height(i_line_height),
        .i_draw_start(i_draw_start),
        .i_draw_end(i_draw_end),
        .i_column(i_column),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_pixel_row(o_pixel_row),
        .o_pixel_column(o_pixel_column),
        .o_pixel_color(o_pixel_color),
        .o_write_enable(o_write_enable),
        .o_column_last(o_column_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    function automatic int unsigned eff_size_log2();
        if (size_log2_q < 3'd1) return 1;
        if (size_log2_q > 3'(TEX_LOG2_MAX)) return TEX_LOG2_MAX;
        return 32'(size_log2_q);
    endfunction

    function automatic logic [11:0] texel_index();
        int unsigned lg;
        int unsigned ty;
        lg = eff_size_log2();
        ty = tex_pos_q[31:16] & ((1 << lg) - 1);
        return 12'((ty << lg) + tex_col_q);
    endfunction

    task automatic predict_pixels(input t_word w);
        int unsigned lg;
        int unsigned sz;
        int unsigned tx;
        logic [15:0] lh;
        longint      k;
        longint      prod;
        logic [23:0] color;
        t_pixel      px;
        lg = eff_size_log2();
        sz = 1 << lg;
        case (w.req)
            REQ_WRITE: begin
                texel_mem[{w.face, w.addr}] = w.value;
                texel_seen[{w.face, w.addr}] = 1'b1;
            end
            REQ_START: begin
                if (!w.side) face_q = w.xneg ? FACE_W : FACE_E;
                else face_q = w.ypos ? FACE_S : FACE_N;
                tx = (w.frac * sz) >> 16;
                if (face_q == FACE_W || face_q == FACE_S) tx = sz - tx - 1;
                tex_col_q = tx[5:0];
                lh = (w.lh == 16'd0) ? 16'd1 : w.lh;
                tex_step_q = (sz << 16) / lh;
                k = longint'(w.ds) - longint'(screen_height_q / 2) + longint'(lh / 2);
                prod = k * longint'(tex_step_q);
                tex_pos_q = prod[31:0];
                end_q = (w.de > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : w.de;
                row_q = {1'b0, w.ds};
                col_q = w.col;
                active_q = row_q < end_q;
            end
            REQ_STEP: begin
                if (active_q) begin
                    color = texel_mem[{face_q, texel_index()}];
                    tex_pos_q = tex_pos_q + tex_step_q;
                    if (face_q == FACE_N || face_q == FACE_E) color = (color >> 1) & DARK_MASK;
                    px.row = row_q[9:0];
                    px.col = col_q;
                    px.color = color;
                    px.we = color != 24'd0;
                    px.last = (row_q + 11'd1) >= end_q;
                    expected_pixels.push_back(px);
                    row_q = row_q + 11'd1;
                    if (px.last) active_q = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < 28);
    endfunction

    function automatic logic [23:0] random_texel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'd0;
        if (r == 1) return 24'hFFFFFF;
        return 24'($urandom);
    endfunction

    function automatic t_word random_word();
        t_word w;
        w.req = 2'($urandom);
        w.face = 2'($urandom);
        w.addr = 12'($urandom);
        w.value = 24'($urandom);
        w.side = 1'($urandom);
        w.xneg = 1'($urandom);
        w.ypos = 1'($urandom);
        w.frac = 16'($urandom);
        w.lh = 16'($urandom);
        w.ds = 10'($urandom);
        w.de = 11'($urandom);
        w.col = 11'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_word w);
        @(negedge i_clk);
        while (take_gap()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_type <= w.req;
        i_face_select <= w.face;
        i_texel_addr <= w.addr;
        i_texel_value <= w.value;
        i_hit_side <= w.side;
        i_dir_x_negative <= w.xneg;
        i_dir_y_positive <= w.ypos;
        i_wall_fraction <= w.frac;
        i_line_height <= w.lh;
        i_draw_start <= w.ds;
        i_draw_end <= w.de;
        i_column <= w.col;
        i_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        predict_pixels(w);
        if (w.req != REQ_UNUSED) words_sent++;
    endtask

    task automatic write_texel(input logic [1:0] face, input logic [11:0] addr,
                               input logic [23:0] value);
        t_word w;
        w = random_word();
        w.req = REQ_WRITE;
        w.face = face;
        w.addr = addr;
        w.value = value;
        send_word(w);
    endtask

    task automatic start_column(input logic side, xneg, ypos, input logic [15:0] frac, lh,
                                input logic [9:0] ds, input logic [10:0] de, col);
        t_word w;
        w = random_word();
        w.req = REQ_START;
        w.side = side;
        w.xneg = xneg;
        w.ypos = ypos;
        w.frac = frac;
        w.lh = lh;
        w.ds = ds;
        w.de = de;
        w.col = col;
        send_word(w);
    endtask

    // a texel is written before any step fetches it
    task automatic step_row();
        t_word       w;
        logic [13:0] slot;
        if (active_q) begin
            slot = {face_q, texel_index()};
            if (!texel_seen[slot]) write_texel(slot[13:12], slot[11:0], random_texel());
        end
        w = random_word();
        w.req = REQ_STEP;
        send_word(w);
    endtask

    task automatic finish_column();
        while (active_q) step_row();
    endtask

    task automatic random_column();
        logic [9:0]  ds;
        logic [10:0] de;
        logic [15:0] lh;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            ds = 10'($urandom);
            de = 11'(ds) + 11'($urandom_range(1, 12));
        end else if (r < 95) begin
            ds = 10'($urandom_range(1008, 1023));
            de = 11'($urandom_range(ds + 1, 2047));
        end else begin
            ds = 10'($urandom);
            de = 11'($urandom_range(0, ds));
        end
        r = $urandom_range(0, 99);
        if (r < 50) lh = 16'($urandom_range(1, 64));
        else if (r < 80) lh = 16'($urandom);
        else lh = 16'($urandom_range(0, 3));
        start_column(1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), lh, ds, de,
                     11'($urandom));
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [10:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == CFG_TEX_SIZE_LOG2) size_log2_q = data[2:0];
        else screen_height_q = data;
        register_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [10:0] size_data, input logic [10:0] height);
        write_register(CFG_TEX_SIZE_LOG2, size_data);
        write_register(CFG_SCREEN_HEIGHT, height);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // one column per face, fraction and column extremes, reset settings
    task automatic test_faces();
        write_texel(FACE_W, 12'hFFF, 24'hFFFFFF);
        write_texel(FACE_N, 12'h000, 24'h000000);
        start_column(1'b0, 1'b1, 1'b0, 16'h0000, 16'd16, 10'd200, 11'd202, 11'd0);
        finish_column();
        start_column(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'd16, 10'd0, 11'd2, 11'd2047);
        finish_column();
        start_column(1'b1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 10'd1023, 11'd1024, 11'd5);
        finish_column();
        start_column(1'b1, 1'b1, 1'b0, 16'h8000, 16'd1, 10'd10, 11'd12, 11'd1);
        finish_column();
        settle();
    endtask

    task automatic test_special_columns();
        t_word w;
        // zero line height
        start_column(1'b0, 1'b0, 1'b0, 16'h1234, 16'd0, 10'd100, 11'd103, 11'd7);
        finish_column();
        // end row past the screen
        start_column(1'b1, 1'b1, 1'b1, 16'hA5A5, 16'd8, 10'd1021, 11'd2047, 11'd9);
        finish_column();
        // empty column, then a step with no active column
        start_column(1'b1, 1'b0, 1'b0, 16'h0F0F, 16'd20, 10'd300, 11'd300, 11'd11);
        step_row();
        step_row();
        w = random_word();
        w.req = REQ_UNUSED;
        send_word(w);
        // start position below zero
        start_column(1'b0, 1'b1, 1'b1, 16'h0000, 16'd2, 10'd0, 11'd3, 11'd3);
        finish_column();
        // texel rewritten right before it is fetched
        start_column(1'b1, 1'b0, 1'b0, 16'h4000, 16'd4, 10'd50, 11'd54, 11'd77);
        step_row();
        write_texel(face_q, texel_index(), random_texel());
        step_row();
        finish_column();
        settle();
    endtask

    task automatic test_config_extremes();
        for (int i = 0; i < 5; i++) begin
            case (i)
                0: set_config(11'd0, 11'd1);
                1: set_config({8'hFF, 3'd7}, 11'd2047);
                2: set_config(11'd1, 11'd0);
                3: set_config(11'd6, 11'd1024);
                default: set_config(11'd3, 11'd480);
            endcase
            repeat (4) begin
                random_column();
                finish_column();
            end
            settle();
        end
    endtask

    task automatic random_sequence();
        t_word w;
        int    pick;
        int    rows;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            w = random_word();
            w.req = REQ_UNUSED;
            send_word(w);
        end else if (pick < 8) begin
            step_row();
        end else if (pick < 13) begin
            w = random_word();
            start_column(w.side, w.xneg, w.ypos, w.frac, w.lh, w.ds,
                         11'($urandom_range(0, w.ds)), w.col);
            step_row();
        end else begin
            repeat ($urandom_range(0, 2))
                write_texel(2'($urandom), 12'($urandom), random_texel());
            random_column();
            // some columns are abandoned by the next start
            rows = (pick < 20) ? $urandom_range(1, 3) : MAX_ROWS;
            while (active_q && rows > 0) begin
                if ($urandom_range(0, 9) == 0)
                    write_texel(2'($urandom), 12'($urandom), random_texel());
                step_row();
                rows--;
            end
        end
    endtask

    task automatic test_random_traffic();
        int target;
        int phase_end;
        int phase;
        int r;
        logic [10:0] height;
        target = words_sent + RANDOM_WORDS;
        phase = 0;
        while (words_sent < target) begin
            r = $urandom_range(0, 9);
            case (r)
                0: height = 11'd0;
                1: height = 11'd1;
                2: height = 11'd2047;
                3: height = 11'd1024;
                default: height = 11'($urandom);
            endcase
            set_config({8'($urandom), 3'($urandom_range(0, 7))}, height);
            no_gaps = (phase == 2);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end && words_sent < target) random_sequence();
            finish_column();
            settle();
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_stall <= take_gap();
    end

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel at row %0d column %0d", o_pixel_row, o_pixel_column);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("pixel_row", 32'(want.row), 32'(o_pixel_row));
                compare_field("pixel_column", 32'(want.col), 32'(o_pixel_column));
                compare_field("pixel_color", 32'(want.color), 32'(o_pixel_color));
                compare_field("write_enable", 32'(want.we), 32'(o_write_enable));
                compare_field("column_last", 32'(want.last), 32'(o_column_last));
                pixels_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req_type = REQ_WRITE;
        i_face_select = FACE_N;
        i_texel_addr = '0;
        i_texel_value = '0;
        i_hit_side = 1'b0;
        i_dir_x_negative = 1'b0;
        i_dir_y_positive = 1'b0;
        i_wall_fraction = '0;
        i_line_height = '0;
        i_draw_start = '0;
        i_draw_end = '0;
        i_column = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TEX_SIZE_LOG2;
        i_cfg_data = '0;
        tex_pos_q = '0;
        tex_step_q = '0;
        face_q = FACE_N;
        tex_col_q = '0;
        row_q = '0;
        end_q = '0;
        col_q = '0;
        active_q = 1'b0;
        size_log2_q = TEX_SIZE_LOG2_RESET;
        screen_height_q = SCREEN_HEIGHT_RESET;
        error_count = 0;
        words_sent = 0;
        pixels_checked = 0;
        register_writes = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_faces();
        test_special_columns();
        test_config_extremes();
        test_random_traffic();

        $display("Sent %0d words, checked %0d pixels, %0d register writes", words_sent,
                 pixels_checked, register_writes);
        $display("All four faces, texture sizes 2 to 64 and out-of-range size codes covered");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
